/* sv/wsf_pkg.sv */
// wsf_pkg: shared types, byte codes and constants of the wheel stepper command framer
// no dependencies; every other file of the block imports this package

package wsf_pkg;

  // command codes carried in the action field
  typedef enum logic [1:0] {
    ACT_ENABLE = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_SPEED  = 2'd3
  } action_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_SPEED    = 3'd0,
    CFG_MOVE_ACCEL    = 3'd1,
    CFG_SPEED_LIMIT   = 3'd2,
    CFG_SPEED_ACCEL   = 3'd3,
    CFG_MOVE_RPM      = 3'd4,
    CFG_STEPS_PER_REV = 3'd5,
    CFG_SETTLE_MARGIN = 3'd6
  } cfg_idx_e;

  // divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN,
    DIV_DONE
  } div_state_e;

  // byte sequencer of the back end
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

  localparam int unsigned NUM_WHEELS = 4;
  // forward direction bit per wheel, wheel 0 in bit 0
  localparam logic [NUM_WHEELS-1:0] FWD_DIR = 4'b0101;

  // frame byte codes
  localparam logic [7:0] CMD_ENABLE = 8'hF3;
  localparam logic [7:0] SUB_ENABLE = 8'hAB;
  localparam logic [7:0] CMD_MOVE   = 8'hFD;
  localparam logic [7:0] CMD_SPEED  = 8'hF6;
  localparam logic [7:0] CMD_STOP   = 8'hFE;
  localparam logic [7:0] SUB_STOP   = 8'h98;
  localparam logic [7:0] SYNC_ADDR  = 8'h00;
  localparam logic [7:0] SYNC_CMD   = 8'hFF;
  localparam logic [7:0] SYNC_SUB   = 8'h66;
  localparam logic [7:0] CHECK_BYTE = 8'h6B;
  localparam logic [7:0] FLAG_ONE   = 8'h01;
  localparam logic [7:0] FLAG_ZERO  = 8'h00;

  // index of the check byte in each frame kind
  localparam logic [3:0] LAST_ENABLE = 4'd5;
  localparam logic [3:0] LAST_STOP   = 4'd4;
  localparam logic [3:0] LAST_MOVE   = 4'd12;
  localparam logic [3:0] LAST_SPEED  = 4'd7;
  localparam logic [3:0] LAST_SYNC   = 4'd3;
  // frame number of the broadcast sync frame
  localparam logic [2:0] SYNC_FRAME  = 3'd4;

  // wait time arithmetic
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam int unsigned NUM_W  = 47;   // max magnitude 2^31 times 60000
  localparam int unsigned DEN_W  = 29;   // 13 bit rpm times 16 bit steps
  localparam int unsigned ITER_W = $clog2(NUM_W);

  // command queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // reset values of the configuration registers
  localparam logic [15:0] RST_MOVE_SPEED    = 16'd1000;
  localparam logic [7:0]  RST_MOVE_ACCEL    = 8'd10;
  localparam logic [15:0] RST_SPEED_LIMIT   = 16'd3000;
  localparam logic [7:0]  RST_SPEED_ACCEL   = 8'd10;
  localparam logic [12:0] RST_MOVE_RPM      = 13'd100;
  localparam logic [15:0] RST_STEPS_PER_REV = 16'd3200;
  localparam logic [15:0] RST_SETTLE_MARGIN = 16'd50;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] fl_pulses;
    logic signed [31:0] fr_pulses;
    logic signed [31:0] rl_pulses;
    logic signed [31:0] rr_pulses;
    logic signed [15:0] fl_speed;
    logic signed [15:0] fr_speed;
    logic signed [15:0] rl_speed;
    logic signed [15:0] rr_speed;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        frame_end;
    logic        last;
    logic [31:0] wait_ms;
  } res_t;

  typedef struct packed {
    logic [15:0] move_speed_word;
    logic [7:0]  move_accel;
    logic [15:0] speed_limit_word;
    logic [7:0]  speed_accel;
    logic [12:0] move_rpm;
    logic [15:0] steps_per_rev;
    logic [15:0] settle_margin_ms;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    action_e                          action;
    logic [NUM_WHEELS-1:0]            dir;
    logic [NUM_WHEELS-1:0][31:0]      mag;
    logic [31:0]                      max_mag;
  } job_t;

  // divider status towards the back end
  typedef struct packed {
    logic        done;
    logic [31:0] wait_ms;
  } div_stat_t;

endpackage

/* sv/wsf_cmd_if.sv */
// wsf_cmd_if: valid/ready channel carrying one four-wheel command
// depends on wsf_pkg

interface wsf_cmd_if import wsf_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/wsf_res_if.sv */
// wsf_res_if: valid/ready channel carrying one byte of the frame stream
// depends on wsf_pkg

interface wsf_res_if import wsf_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/wheel_stepper_command_framer.sv */
// wheel_stepper_command_framer: top level, configuration registers and block wiring
// depends on wsf_pkg, wsf_cmd_if, wsf_res_if, wsf_front, wsf_fifo, wsf_div, wsf_back
//
//   channel   dir  transfer      payload
//   cmd_i     in   valid/ready   action, four pulse counts, four speeds
//   res_o     out  valid/ready   tx_byte, frame_end, last, wait_ms
//   cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// one command gives 28 (enable), 24 (stop), 56 (move) or 36 (speed) bytes, one
// per cycle from the back end's output register while the output is ready;
// that byte rate sets throughput. the first byte passes the front stage and queue;
// the next command is taken and queued while the current one is still being sent.
// a move's last byte waits for the 47-step divider, which runs during the frames.
// reset clears control state and loads the configuration defaults; no sweep.
// a stalled output holds its byte; the front stalls only once the queue is full.

module wheel_stepper_command_framer import wsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wsf_cmd_if.sink              cmd_i,
  wsf_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t      cfg_q;
  job_t      front_job, queue_job;
  logic      front_valid, queue_ready, queue_valid, queue_pop;
  logic      div_start;
  div_stat_t div_stat;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_speed_word  <= RST_MOVE_SPEED;
      cfg_q.move_accel       <= RST_MOVE_ACCEL;
      cfg_q.speed_limit_word <= RST_SPEED_LIMIT;
      cfg_q.speed_accel      <= RST_SPEED_ACCEL;
      cfg_q.move_rpm         <= RST_MOVE_RPM;
      cfg_q.steps_per_rev    <= RST_STEPS_PER_REV;
      cfg_q.settle_margin_ms <= RST_SETTLE_MARGIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOVE_SPEED:    cfg_q.move_speed_word  <= cfg_data_i;
        CFG_MOVE_ACCEL:    cfg_q.move_accel       <= cfg_data_i[7:0];
        CFG_SPEED_LIMIT:   cfg_q.speed_limit_word <= cfg_data_i;
        CFG_SPEED_ACCEL:   cfg_q.speed_accel      <= cfg_data_i[7:0];
        CFG_MOVE_RPM:      cfg_q.move_rpm         <= cfg_data_i[12:0];
        CFG_STEPS_PER_REV: cfg_q.steps_per_rev    <= cfg_data_i;
        CFG_SETTLE_MARGIN: cfg_q.settle_margin_ms <= cfg_data_i;
        default:           cfg_q                  <= cfg_q;
      endcase
    end
  end

  // command intake and classification
  wsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .speed_limit_i (cfg_q.speed_limit_word),
    .job_o         (front_job),
    .job_valid_o   (front_valid),
    .job_ready_i   (queue_ready)
  );

  // queue between front and back
  wsf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .pop_data_o   (queue_job),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop)
  );

  // settle wait of a move
  wsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .max_mag_i  (queue_job.max_mag),
    .move_rpm_i (cfg_q.move_rpm),
    .steps_i    (cfg_q.steps_per_rev),
    .margin_i   (cfg_q.settle_margin_ms),
    .stat_o     (div_stat)
  );

  // frame serialiser
  wsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_valid_i (queue_valid),
    .pop_o       (queue_pop),
    .cfg_i       (cfg_q),
    .div_start_o (div_start),
    .div_i       (div_stat),
    .res_o       (res_o)
  );

endmodule

/* sv/wsf_front.sv */
// wsf_front: accepts commands, takes magnitudes and direction bits per wheel
// depends on wsf_pkg and wsf_cmd_if

module wsf_front import wsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsf_cmd_if.sink     cmd_i,
  input  logic [15:0] speed_limit_i,
  output job_t        job_o,
  output logic        job_valid_o,
  input  logic        job_ready_i
);

  logic                        s1_valid_q;
  action_e                     s1_act_q;
  logic [NUM_WHEELS-1:0]       s1_dir_q, s1_dir_d;
  logic [NUM_WHEELS-1:0][31:0] s1_abs_q, s1_abs_d;
  logic [NUM_WHEELS-1:0][31:0] pulses;
  logic [NUM_WHEELS-1:0][15:0] speeds;
  logic                        take;
  logic [31:0]                 max01, max23;

  assign pulses = {cmd_i.data.rr_pulses, cmd_i.data.rl_pulses,
                   cmd_i.data.fr_pulses, cmd_i.data.fl_pulses};
  assign speeds = {cmd_i.data.rr_speed, cmd_i.data.rl_speed,
                   cmd_i.data.fr_speed, cmd_i.data.fl_speed};

  // stage register frees up as soon as the queue takes its content
  assign cmd_i.ready = !s1_valid_q || job_ready_i;
  assign take        = cmd_i.valid && cmd_i.ready;

  // magnitude and direction per wheel
  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (cmd_i.data.action == ACT_SPEED) begin
        s1_dir_d[w] = FWD_DIR[w] ^ speeds[w][15];
        s1_abs_d[w] = {16'd0, (speeds[w][15] ? (16'd0 - speeds[w]) : speeds[w])};
      end else begin
        s1_dir_d[w] = FWD_DIR[w] ^ pulses[w][31];
        s1_abs_d[w] = pulses[w][31] ? (32'd0 - pulses[w]) : pulses[w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_act_q <= cmd_i.data.action;
      s1_dir_q <= s1_dir_d;
      s1_abs_q <= s1_abs_d;
    end
  end

  // speed clamp and largest move magnitude
  always_comb begin
    max01 = (s1_abs_q[0] > s1_abs_q[1]) ? s1_abs_q[0] : s1_abs_q[1];
    max23 = (s1_abs_q[2] > s1_abs_q[3]) ? s1_abs_q[2] : s1_abs_q[3];
    job_o.action  = s1_act_q;
    job_o.dir     = s1_dir_q;
    job_o.max_mag = (max01 > max23) ? max01 : max23;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (s1_act_q == ACT_SPEED && s1_abs_q[w][15:0] > speed_limit_i) begin
        job_o.mag[w] = {16'd0, speed_limit_i};
      end else begin
        job_o.mag[w] = s1_abs_q[w];
      end
    end
  end

  assign job_valid_o = s1_valid_q;

endmodule

/* sv/wsf_fifo.sv */
// wsf_fifo: short queue of classified commands between front and back
// depends on wsf_pkg

module wsf_fifo import wsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_i
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push;

  assign push_ready_o = count_q != (QPTR_W+1)'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/wsf_div.sv */
// wsf_div: settle wait of a move, ceil(max*60000 / (rpm*steps)) plus margin
// depends on wsf_pkg; restoring divider, one quotient bit per cycle

module wsf_div import wsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] max_mag_i,
  input  logic [12:0] move_rpm_i,
  input  logic [15:0] steps_i,
  input  logic [15:0] margin_i,
  output div_stat_t   stat_o
);

  div_state_e        state_q, state_d;
  logic [ITER_W-1:0] cnt_q;
  logic [DEN_W-1:0]  den_q, rem_q, den_full;
  logic [NUM_W-1:0]  quo_q;
  logic [47:0]       num_full;
  logic [DEN_W:0]    trial, trial_sub;
  logic              ge;
  logic [NUM_W:0]    sum;
  logic [31:0]       wait_q, wait_d;

  assign num_full  = max_mag_i * MS_PER_MIN;
  assign den_full  = move_rpm_i * steps_i;
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  // round up, add margin, saturate; zero divisor gives all ones
  always_comb begin
    sum = {1'b0, quo_q} + {(NUM_W-15)'(0), margin_i} + {{NUM_W{1'b0}}, (rem_q != '0)};
    if (den_q == '0 || sum[NUM_W:32] != '0) begin
      wait_d = '1;
    end else begin
      wait_d = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = DIV_RUN;
    end else begin
      unique case (state_q)
        DIV_IDLE: state_d = DIV_IDLE;
        DIV_RUN:  state_d = (cnt_q == ITER_W'(NUM_W-1)) ? DIV_FIN : DIV_RUN;
        DIV_FIN:  state_d = DIV_DONE;
        DIV_DONE: state_d = DIV_DONE;
        default:  state_d = DIV_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    stat_o.done    = state_q == DIV_DONE;
    stat_o.wait_ms = wait_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        cnt_q <= '0;
      end else if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // operand load, shift-subtract steps, final result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_full[NUM_W-1:0];
      den_q <= den_full;
      rem_q <= '0;
    end else if (state_q == DIV_RUN) begin
      rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end else if (state_q == DIV_FIN) begin
      wait_q <= wait_d;
    end
  end

endmodule

/* sv/wsf_back.sv */
// wsf_back: serialises a classified command into driver frames, one byte per cycle
// unless output or wsf_div's settle wait holds it; depends on wsf_pkg, wsf_res_if

module wsf_back import wsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      pop_o,
  input  cfg_t      cfg_i,
  output logic      div_start_o,
  input  div_stat_t div_i,
  wsf_res_if.source res_o
);

  bk_state_e   state_q, state_d;
  job_t        cur_q;
  logic [2:0]  frame_q;
  logic [3:0]  idx_q;
  logic        ov_q;
  res_t        out_q;
  logic [7:0]  addr, sel_dir, tx_byte;
  logic [31:0] sel_mag;
  logic [3:0]  last_idx;
  logic        frame_end, is_last, can_emit, hold_last, emit;

  assign addr    = {5'd0, frame_q} + 8'd1;
  assign sel_mag = cur_q.mag[frame_q[1:0]];
  assign sel_dir = {7'd0, cur_q.dir[frame_q[1:0]]};

  // byte of the current frame position
  always_comb begin
    tx_byte  = CHECK_BYTE;
    last_idx = LAST_SYNC;
    if (frame_q == SYNC_FRAME) begin
      last_idx = LAST_SYNC;
      case (idx_q)
        4'd0:    tx_byte = SYNC_ADDR;
        4'd1:    tx_byte = SYNC_CMD;
        4'd2:    tx_byte = SYNC_SUB;
        default: tx_byte = CHECK_BYTE;
      endcase
    end else begin
      case (cur_q.action)
        ACT_ENABLE: begin
          last_idx = LAST_ENABLE;
          case (idx_q)
            4'd0:        tx_byte = addr;
            4'd1:        tx_byte = CMD_ENABLE;
            4'd2:        tx_byte = SUB_ENABLE;
            4'd3, 4'd4:  tx_byte = FLAG_ONE;
            default:     tx_byte = CHECK_BYTE;
          endcase
        end
        ACT_STOP: begin
          last_idx = LAST_STOP;
          case (idx_q)
            4'd0:    tx_byte = addr;
            4'd1:    tx_byte = CMD_STOP;
            4'd2:    tx_byte = SUB_STOP;
            4'd3:    tx_byte = FLAG_ONE;
            default: tx_byte = CHECK_BYTE;
          endcase
        end
        ACT_MOVE: begin
          last_idx = LAST_MOVE;
          case (idx_q)
            4'd0:    tx_byte = addr;
            4'd1:    tx_byte = CMD_MOVE;
            4'd2:    tx_byte = sel_dir;
            4'd3:    tx_byte = cfg_i.move_speed_word[15:8];
            4'd4:    tx_byte = cfg_i.move_speed_word[7:0];
            4'd5:    tx_byte = cfg_i.move_accel;
            4'd6:    tx_byte = sel_mag[31:24];
            4'd7:    tx_byte = sel_mag[23:16];
            4'd8:    tx_byte = sel_mag[15:8];
            4'd9:    tx_byte = sel_mag[7:0];
            4'd10:   tx_byte = FLAG_ZERO;
            4'd11:   tx_byte = FLAG_ONE;
            default: tx_byte = CHECK_BYTE;
          endcase
        end
        default: begin
          last_idx = LAST_SPEED;
          case (idx_q)
            4'd0:    tx_byte = addr;
            4'd1:    tx_byte = CMD_SPEED;
            4'd2:    tx_byte = sel_dir;
            4'd3:    tx_byte = sel_mag[15:8];
            4'd4:    tx_byte = sel_mag[7:0];
            4'd5:    tx_byte = cfg_i.speed_accel;
            4'd6:    tx_byte = FLAG_ONE;
            default: tx_byte = CHECK_BYTE;
          endcase
        end
      endcase
    end
  end

  assign frame_end = idx_q == last_idx;
  assign is_last   = frame_end && (frame_q == SYNC_FRAME);

  // handshake towards the queue, the divider and the output register
  always_comb begin
    can_emit    = !ov_q || res_o.ready;
    hold_last   = is_last && (cur_q.action == ACT_MOVE) && !div_i.done;
    emit        = (state_q == BK_RUN) && can_emit && !hold_last;
    pop_o       = job_valid_i && ((state_q == BK_IDLE) || (emit && is_last));
    div_start_o = pop_o;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: state_d = pop_o ? BK_RUN : BK_IDLE;
      BK_RUN:  state_d = (emit && is_last && !pop_o) ? BK_IDLE : BK_RUN;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      frame_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        frame_q <= '0;
        idx_q   <= '0;
      end else if (emit) begin
        if (frame_end) begin
          frame_q <= frame_q + 3'd1;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // current command and output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (emit) begin
      out_q.tx_byte   <= tx_byte;
      out_q.frame_end <= frame_end;
      out_q.last      <= is_last;
      out_q.wait_ms   <= (is_last && cur_q.action == ACT_MOVE) ? div_i.wait_ms : 32'd0;
    end
  end

  assign res_o.valid = ov_q;
  assign res_o.data  = out_q;

`ifndef SYNTH
  a_wait_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.last) |-> (res_o.data.wait_ms == 32'd0))
    else $error("wait time on a byte other than the last");
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.last) |-> res_o.data.frame_end)
    else $error("last byte is not a check byte");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> job_valid_i)
    else $error("command taken from an empty queue");
  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (frame_q <= SYNC_FRAME))
    else $error("frame counter beyond the sync frame");
`endif

endmodule
